FILE: hw/rtl/gbda_pkg.sv
// Shared types and constants of the gene block distance accumulator.
package gbda_pkg;

   // Width of one gene block and of the input words.
   localparam int BLOCK_W   = 8;
   localparam int MAX_LANES = 8;
   localparam int WORD_W    = BLOCK_W * MAX_LANES;

   // Width of the item match count, which holds up to two hits per lane.
   localparam int MATCH_W = 5;

   // Width of the running sum and of the reported distance.
   localparam int DIST_W = 26;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // Configuration register indexes, taken from paddr[2].
   localparam logic REG_LOWER_MASK = 1'b0;
   localparam logic REG_UPPER_MASK = 1'b1;

   // Configuration bus widths.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // Reset values of the gene masks.
   localparam logic [BLOCK_W-1:0] LOWER_MASK_RESET = 8'h0F;
   localparam logic [BLOCK_W-1:0] UPPER_MASK_RESET = 8'hF0;

   // Merged item held between the lane stage and the accumulator.
   typedef struct packed {
      logic               vld;
      logic               last;
      logic [MATCH_W-1:0] hit_count;
   } item_type;

endpackage

FILE: hw/rtl/gbda_lane.sv
// One byte lane: counts the gene halves of a block pair that share no bits.
module gbda_lane (
   input  logic [gbda_pkg::BLOCK_W-1:0] first_block,
   input  logic [gbda_pkg::BLOCK_W-1:0] second_block,
   input  logic [gbda_pkg::BLOCK_W-1:0] lower_mask,
   input  logic [gbda_pkg::BLOCK_W-1:0] upper_mask,
   input  logic                         lane_on,
   output logic [1:0]                   hits
);

   logic [gbda_pkg::BLOCK_W-1:0] both;
   logic                         lower_hit;
   logic                         upper_hit;

   // A half counts when the masked common bits are all clear.
   assign both      = first_block & second_block;
   assign lower_hit = lane_on && ((both & lower_mask) == '0);
   assign upper_hit = lane_on && ((both & upper_mask) == '0);
   assign hits      = {1'b0, lower_hit} + {1'b0, upper_hit};

endmodule

FILE: hw/rtl/gbda_merge.sv
// Merging stage: adds the lane hits of one item and holds the result.
module gbda_merge #(
   parameter int LANES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    advance,
   input  logic [LANES-1:0][1:0]   lane_hits,
   input  logic                    last_item,
   output gbda_pkg::item_type      item
);

   gbda_pkg::item_type                 item_ff;
   gbda_pkg::item_type                 item_in;
   logic [gbda_pkg::MATCH_W-1:0]       total;

   // Sum of the lane counts; lanes are independent so this is a short tree.
   always_comb begin
      total = '0;
      for (int k = 0; k < LANES; k++) begin
         total = total + gbda_pkg::MATCH_W'(lane_hits[k]);
      end
   end

   // The stage takes a new item on a transfer and empties when it moves on.
   always_comb begin
      item_in = item_ff;
      if (load) begin
         item_in.vld       = 1'b1;
         item_in.last      = last_item;
         item_in.hit_count = total;
      end else if (advance) begin
         item_in.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.vld <= 1'b0;
      end else begin
         item_ff.vld <= item_in.vld;
      end
      item_ff.last      <= item_in.last;
      item_ff.hit_count <= item_in.hit_count;
   end

   assign item = item_ff;

endmodule

FILE: hw/rtl/gbda_accum.sv
// Running sum with saturation and the result output register.
module gbda_accum #(
   parameter logic [gbda_pkg::DIST_W-1:0] SUM_CAP = '1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gbda_pkg::item_type            item,
   input  logic                          advance,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [gbda_pkg::DIST_W-1:0]   distance
);

   logic [gbda_pkg::DIST_W-1:0] sum_ff;
   logic [gbda_pkg::DIST_W-1:0] sum_in;
   logic                        out_vld_ff;
   logic                        out_vld_in;
   logic [gbda_pkg::DIST_W-1:0] dist_ff;
   logic [gbda_pkg::DIST_W-1:0] dist_in;
   logic [gbda_pkg::DIST_W:0]   sum_wide;
   logic [gbda_pkg::DIST_W-1:0] sum_sat;

   // One add and one compare against the cap.
   assign sum_wide = {1'b0, sum_ff} + (gbda_pkg::DIST_W + 1)'(item.hit_count);
   assign sum_sat  = (sum_wide > {1'b0, SUM_CAP}) ? SUM_CAP
                                                  : sum_wide[gbda_pkg::DIST_W-1:0];

   // A last item reports the total and clears the sum for the next pair.
   always_comb begin
      sum_in     = sum_ff;
      out_vld_in = out_vld_ff;
      dist_in    = dist_ff;
      if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (advance) begin
         if (item.last) begin
            sum_in     = '0;
            out_vld_in = 1'b1;
            dist_in    = sum_sat;
         end else begin
            sum_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         out_vld_ff <= out_vld_in;
      end
      dist_ff <= dist_in;
   end

   assign rsp_valid = out_vld_ff;
   assign distance  = dist_ff;

endmodule

FILE: hw/rtl/gene_block_distance_accumulator_core.sv
// Gene block distance accumulator: takes one item per clock cycle when the
// result side keeps up. Each item passes through the byte lanes and the merging
// stage into a register in the transfer cycle, and from that register the single
// accumulator adder folds it into the running sum; a last item's distance is
// loaded into the output register and offered on the rsp_ channel. That one adder
// sets the throughput at one item per cycle. A last item waits in the merging
// stage only while an earlier distance is still held in the output register;
// other items never wait. The gene masks are written through the APB port at
// byte addresses 0 (lower mask) and 4 (upper mask); the user must write them
// only while the block is idle, which the block itself does not enforce.
module gene_block_distance_accumulator_core #(
   parameter int              LANES      = 8,
   parameter longint unsigned MAX_BLOCKS = 16777216
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gbda_pkg::WORD_W-1:0]       req_first_blocks,
   input  logic [gbda_pkg::WORD_W-1:0]       req_second_blocks,
   input  logic [3:0]                        req_valid_count,
   input  logic                              req_last_item,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gbda_pkg::DIST_W-1:0]       rsp_distance,
   // Configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gbda_pkg::ADDR_W-1:0]       paddr,
   input  logic [gbda_pkg::DATA_W-1:0]       pwdata,
   output logic [gbda_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   localparam longint unsigned CAP_TWICE = 64'(MAX_BLOCKS) * 64'd2;
   localparam longint unsigned CAP_FULL  = 64'(gbda_pkg::DIST_MAX);
   localparam logic [gbda_pkg::DIST_W-1:0] SUM_CAP =
      gbda_pkg::DIST_W'((CAP_TWICE < CAP_FULL) ? CAP_TWICE : CAP_FULL);

   logic [gbda_pkg::BLOCK_W-1:0] lower_mask_ff;
   logic [gbda_pkg::BLOCK_W-1:0] lower_mask_in;
   logic [gbda_pkg::BLOCK_W-1:0] upper_mask_ff;
   logic [gbda_pkg::BLOCK_W-1:0] upper_mask_in;
   logic                         csr_write;
   logic                         csr_index;
   logic [LANES-1:0][1:0]        lane_hits;
   gbda_pkg::item_type           item;
   logic                         load;
   logic                         advance;
   logic                         slot_free;

   // Register writes complete in the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_comb begin
      lower_mask_in = lower_mask_ff;
      upper_mask_in = upper_mask_ff;
      if (csr_write) begin
         case (csr_index)
            gbda_pkg::REG_LOWER_MASK: begin
               lower_mask_in = pwdata[gbda_pkg::BLOCK_W-1:0];
            end
            gbda_pkg::REG_UPPER_MASK: begin
               upper_mask_in = pwdata[gbda_pkg::BLOCK_W-1:0];
            end
            default: begin
               lower_mask_in = lower_mask_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_mask_ff <= gbda_pkg::LOWER_MASK_RESET;
         upper_mask_ff <= gbda_pkg::UPPER_MASK_RESET;
      end else begin
         lower_mask_ff <= lower_mask_in;
         upper_mask_ff <= upper_mask_in;
      end
   end

   // Read-back of the masks.
   always_comb begin
      case (csr_index)
         gbda_pkg::REG_LOWER_MASK: begin
            prdata = gbda_pkg::DATA_W'(lower_mask_ff);
         end
         gbda_pkg::REG_UPPER_MASK: begin
            prdata = gbda_pkg::DATA_W'(upper_mask_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Flow control: only a last item needs the output register to be free.
   assign slot_free = !rsp_valid || rsp_ready;
   assign advance   = item.vld && (!item.last || slot_free);
   assign req_ready = !item.vld || advance;
   assign load      = req_valid && req_ready;

   // One lane per block byte; lanes above the valid count stay silent.
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      gbda_lane u_lane (
         .first_block  (req_first_blocks[k*gbda_pkg::BLOCK_W +: gbda_pkg::BLOCK_W]),
         .second_block (req_second_blocks[k*gbda_pkg::BLOCK_W +: gbda_pkg::BLOCK_W]),
         .lower_mask   (lower_mask_ff),
         .upper_mask   (upper_mask_ff),
         .lane_on      (req_valid_count > 4'(k)),
         .hits         (lane_hits[k])
      );
   end

   gbda_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .advance   (advance),
      .lane_hits (lane_hits),
      .last_item (req_last_item),
      .item      (item)
   );

   gbda_accum #(
      .SUM_CAP (SUM_CAP)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .advance   (advance),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .distance  (rsp_distance)
   );

endmodule

FILE: hw/rtl/gbda_checker.sv
// Port-level checks of the distance accumulator, bound to the top level.
module gbda_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [gbda_pkg::DIST_W-1:0]     rsp_distance
);

   // A distance that is not taken stays on offer unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("held result changed before its transfer");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // With room at the output the input side never stalls.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled although the output register is free");

endmodule

bind gene_block_distance_accumulator_core gbda_checker u_gbda_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_distance (rsp_distance)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the gene block distance accumulator core.
`timescale 1ns / 1ps

module tb_top;

   localparam int              LANES       = 8;
   localparam longint unsigned MAX_BLOCKS  = 16777216;
   localparam longint unsigned WIDTH_TOP   = 64'h3FFFFFF;
   localparam longint unsigned SUM_CAP     = (2 * MAX_BLOCKS < WIDTH_TOP) ? 2 * MAX_BLOCKS
                                                                         : WIDTH_TOP;
   localparam int              PHASES      = 5;
   localparam int              PHASE_ITEMS = 400;
   localparam int              CYCLE_LIMIT = 300000;

   // Predicts the distance of each sequence pair and checks the reported ones.
   class distance_scoreboard;
      logic [gbda_pkg::BLOCK_W-1:0] lower_mask;
      logic [gbda_pkg::BLOCK_W-1:0] upper_mask;
      logic [gbda_pkg::DIST_W-1:0]  running_sum;
      logic [gbda_pkg::DIST_W-1:0]  distances_due[$];
      int                           errors;

      function new();
         lower_mask  = gbda_pkg::LOWER_MASK_RESET;
         upper_mask  = gbda_pkg::UPPER_MASK_RESET;
         running_sum = '0;
         errors      = 0;
      endfunction

      function void set_mask(input logic idx, input logic [gbda_pkg::BLOCK_W-1:0] mask);
         if (idx == gbda_pkg::REG_LOWER_MASK) begin
            lower_mask = mask;
         end else begin
            upper_mask = mask;
         end
      endfunction

      function int pending();
         return distances_due.size();
      endfunction

      // Folds one accepted item into the running sum; a last item yields a distance.
      function void note_transfer(input logic [gbda_pkg::WORD_W-1:0] first_w,
                                  input logic [gbda_pkg::WORD_W-1:0] second_w,
                                  input logic [3:0] count, input logic last);
         logic [gbda_pkg::WORD_W-1:0]  both;
         logic [gbda_pkg::BLOCK_W-1:0] shared;
         int unsigned                  lanes;
         int unsigned                  hits;
         longint unsigned              total;
         lanes = count;
         if (lanes > LANES) begin
            lanes = LANES;
         end
         both = first_w & second_w;
         hits = 0;
         for (int k = 0; k < gbda_pkg::MAX_LANES; k++) begin
            if (k < lanes) begin
               shared = both[gbda_pkg::BLOCK_W*k +: gbda_pkg::BLOCK_W];
               if ((shared & lower_mask) == '0) begin
                  hits++;
               end
               if ((shared & upper_mask) == '0) begin
                  hits++;
               end
            end
         end
         total = longint'(running_sum) + hits;
         if (total > SUM_CAP) begin
            total = SUM_CAP;
         end
         if (last) begin
            distances_due.push_back(total[gbda_pkg::DIST_W-1:0]);
            running_sum = '0;
         end else begin
            running_sum = total[gbda_pkg::DIST_W-1:0];
         end
      endfunction

      // Compares a reported distance with the oldest one predicted.
      function void check_distance(input logic [gbda_pkg::DIST_W-1:0] actual);
         logic [gbda_pkg::DIST_W-1:0] predicted;
         if (distances_due.size() == 0) begin
            $error("distance: nothing expected, got %0d", actual);
            errors++;
         end else begin
            predicted = distances_due.pop_front();
            if (actual !== predicted) begin
               $error("distance: expected %0d, got %0d", predicted, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_ready;
   logic [gbda_pkg::WORD_W-1:0]   req_first_blocks  = '0;
   logic [gbda_pkg::WORD_W-1:0]   req_second_blocks = '0;
   logic [3:0]                    req_valid_count   = '0;
   logic                          req_last_item     = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready         = 1'b0;
   logic [gbda_pkg::DIST_W-1:0]   rsp_distance;
   logic                          psel              = 1'b0;
   logic                          penable           = 1'b0;
   logic                          pwrite            = 1'b0;
   logic [gbda_pkg::ADDR_W-1:0]   paddr             = '0;
   logic [gbda_pkg::DATA_W-1:0]   pwdata            = '0;
   logic [gbda_pkg::DATA_W-1:0]   prdata;
   logic                          pready;

   distance_scoreboard sb = new();
   bit                 gaps_on = 1'b1;
   int                 cycle_count = 0;

   gene_block_distance_accumulator_core #(
      .LANES      (LANES),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_first_blocks  (req_first_blocks),
      .req_second_blocks (req_second_blocks),
      .req_valid_count   (req_valid_count),
      .req_last_item     (req_last_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_distance      (rsp_distance),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Both channels are observed at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_transfer(req_first_blocks, req_second_blocks, req_valid_count,
                             req_last_item);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_distance(rsp_distance);
         end
      end
   end

   // The result side stalls in short random bursts while gaps are enabled.
   always begin
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // Offers one item and holds it until the transfer completes.
   task automatic send_item(input logic [gbda_pkg::WORD_W-1:0] first_w,
                            input logic [gbda_pkg::WORD_W-1:0] second_w,
                            input logic [3:0] count, input logic last);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_first_blocks  <= first_w;
      req_second_blocks <= second_w;
      req_valid_count   <= count;
      req_last_item     <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Withdraws the input channel and waits until every distance has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      // Non-last items leave no trace on the result side, so allow the pipeline to empty.
      repeat (6) @(negedge clock);
   endtask

   // Writes a gene mask over APB, then reads it back.
   task automatic program_mask(input logic idx, input logic [gbda_pkg::BLOCK_W-1:0] mask);
      logic [gbda_pkg::DATA_W-1:0] data;
      data          = $urandom;
      data[7:0]     = mask;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_mask(idx, mask);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== mask) begin
         $error("%s: expected %0h, got %0h",
                (idx == gbda_pkg::REG_LOWER_MASK) ? "lower_gene_mask" : "upper_gene_mask",
                mask, prdata[7:0]);
         sb.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Mask values favour the extremes and single bits.
   function automatic logic [gbda_pkg::BLOCK_W-1:0] pick_mask();
      case ($urandom_range(0, 4))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h01 << $urandom_range(0, 7);
         default: return 8'($urandom);
      endcase
   endfunction

   // Random item: mostly well-formed sequence content with varied overlap.
   task automatic send_random_item();
      logic [gbda_pkg::WORD_W-1:0] first_w;
      logic [gbda_pkg::WORD_W-1:0] second_w;
      logic [3:0]                  count;
      int                          pick;
      first_w  = {$urandom, $urandom};
      second_w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       second_w = ~first_w;
         1:       begin first_w = '1; second_w = '1; end
         2, 3:    second_w = second_w & {$urandom, $urandom};
         default: ;
      endcase
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
         count = 4'd8;
      end else if (pick < 17) begin
         count = 4'($urandom_range(1, 7));
      end else if (pick == 17) begin
         count = 4'd0;
      end else begin
         count = 4'($urandom_range(9, 15));
      end
      send_item(first_w, second_w, count, $urandom_range(0, 5) == 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items with the reset masks.
      send_item('0, '0, 4'd8, 1'b1);
      send_item('1, '1, 4'd8, 1'b1);
      send_item('0, '0, 4'd0, 1'b1);
      send_item('0, '0, 4'd15, 1'b0);
      send_item('0, '0, 4'd9, 1'b1);
      send_item(64'h0F0F_0F0F_0F0F_0F0F, '1, 4'd8, 1'b0);
      send_item(64'hF0F0_F0F0_F0F0_F0F0, '1, 4'd4, 1'b1);
      send_item('1, '0, 4'd1, 1'b1);
      send_item(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 4'd8, 1'b1);
      drain();

      // Zero masks count every valid half as a match.
      program_mask(gbda_pkg::REG_LOWER_MASK, 8'h00);
      program_mask(gbda_pkg::REG_UPPER_MASK, 8'h00);
      send_item('1, '1, 4'd8, 1'b1);
      send_item('1, '1, 4'd3, 1'b0);
      send_item('1, '1, 4'd5, 1'b1);
      drain();

      // Full masks: a half matches only when the shared byte is empty.
      program_mask(gbda_pkg::REG_LOWER_MASK, 8'hFF);
      program_mask(gbda_pkg::REG_UPPER_MASK, 8'hFF);
      send_item('0, '0, 4'd8, 1'b1);
      send_item('1, '1, 4'd8, 1'b1);
      send_item(64'h0000_0000_0000_0100, '1, 4'd2, 1'b1);
      drain();

      // Single-bit masks at opposite ends of the byte.
      program_mask(gbda_pkg::REG_LOWER_MASK, 8'h01);
      program_mask(gbda_pkg::REG_UPPER_MASK, 8'h80);
      send_item(64'h8181_8181_0101_8080, '1, 4'd8, 1'b0);
      send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 4'd7, 1'b1);
      drain();

      // Random phases, each under its own pair of masks.
      for (int phase = 0; phase < PHASES; phase++) begin
         program_mask(gbda_pkg::REG_LOWER_MASK, pick_mask());
         program_mask(gbda_pkg::REG_UPPER_MASK, pick_mask());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == PHASES - 1 && n == PHASE_ITEMS * 5 / 8) begin
               gaps_on = 1'b0;
            end
            send_random_item();
         end
         send_item({$urandom, $urandom}, {$urandom, $urandom}, 4'd8, 1'b1);
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
